FILE: src/sult_pkg.sv
package sult_pkg;

    localparam int CAPACITY = 64;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;
    localparam int COUNT_W = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DUP,
        ST_FULL,
        ST_RANGE
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic                      eval;
        logic                      ins;
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]         rank;
    } cell_ctrl_t;

endpackage

FILE: src/sult_cell.sv
module sult_cell #(
    parameter int CAPACITY = sult_pkg::CAPACITY,
    parameter int IDX      = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sult_pkg::cell_ctrl_t                ctrl,
    input  logic                                live,
    input  logic signed [sult_pkg::VALUE_W-1:0] prev_val,
    input  logic                                prev_ge,
    output logic signed [sult_pkg::VALUE_W-1:0] val,
    output logic                                ge,
    output logic                                eq,
    output logic [sult_pkg::VALUE_W-1:0]        rd
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IW+sult_pkg::RANK_W-1:0] IDX_EXT = (IW + sult_pkg::RANK_W)'(IDX);

    logic signed [sult_pkg::VALUE_W-1:0] val_reg;
    logic signed [sult_pkg::VALUE_W-1:0] val_next;
    logic ge_reg;
    logic ge_next;
    logic eq_reg;
    logic eq_next;
    logic hit_reg;
    logic hit_next;

    always_comb
    begin
        ge_next  = !live || ($signed(val_reg) >= $signed(ctrl.value));
        eq_next  = live && (val_reg == ctrl.value);
        hit_next = ({IW'(0), ctrl.rank} == IDX_EXT);
        val_next = val_reg;
        if (ctrl.ins)
        begin
            if (prev_ge)
            begin
                val_next = prev_val;
            end
            else if (ge_reg)
            begin
                val_next = ctrl.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else if (ctrl.eval)
        begin
            ge_reg  <= ge_next;
            eq_reg  <= eq_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign ge  = ge_reg;
    assign eq  = eq_reg;
    assign rd  = hit_reg ? val_reg : '0;

endmodule

FILE: src/sorted_unique_level_table_top.sv
// Sorted table of signed Q16.16 levels, kept strictly ascending with no duplicates.
// An item is taken when start is high and busy is low; busy then stays high through
// the eval and apply states; the result is shown for one cycle with done high once
// busy is low again, so a new item waits until the last is through. In the eval
// state every cell compares its entry with the new level and registers the outcome;
// in the apply state a kept insert shifts the cells from the insertion point up by
// one place and the result is formed. The receiver cannot stall: a result must be
// taken in the cycle that done is high. An insert of a stored level reports a
// duplicate, an insert into a full table reports the drop, and a read at a rank at
// or above the count reports the rank as out of range with read_value zero.
module sorted_unique_level_table_top #(
    parameter int CAPACITY = sult_pkg::CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                command,
    input  logic signed [sult_pkg::VALUE_W-1:0] value,
    input  logic [sult_pkg::RANK_W-1:0]         rank,
    output logic                                done,
    output logic signed [sult_pkg::VALUE_W-1:0] read_value,
    output logic [sult_pkg::COUNT_W-1:0]        entry_count,
    output logic [1:0]                          status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = sult_pkg::RANK_W;
    localparam int VW = sult_pkg::VALUE_W;

    sult_pkg::state_t state_reg;
    sult_pkg::state_t state_next;

    logic              cmd_reg;
    logic signed [VW-1:0] val_reg;
    logic [RW-1:0]     rank_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    logic              done_reg;
    logic              done_next;
    sult_pkg::status_t status_reg;
    sult_pkg::status_t status_next;
    logic [VW-1:0]     rdval_reg;
    logic [VW-1:0]     rdval_next;
    logic [sult_pkg::COUNT_W-1:0] cnt_out_reg;
    logic [sult_pkg::COUNT_W-1:0] cnt_out_next;
    logic [CW+sult_pkg::COUNT_W-1:0] cnt_ext;

    sult_pkg::cell_ctrl_t ctrl;

    logic signed [VW-1:0] cell_val [CAPACITY];
    logic [VW-1:0]        cell_rd  [CAPACITY];
    logic [CAPACITY-1:0]  cell_ge;
    logic [CAPACITY-1:0]  cell_eq;
    logic [CAPACITY-1:0]  live;

    logic          dup;
    logic          full;
    logic          rank_ok;
    logic          do_ins;
    logic [VW-1:0] rd_any;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam logic [CW-1:0] I_CW = CW'(i);

            assign live[i] = (I_CW < count_reg);

            if (i == 0)
            begin : g_head
                sult_cell #(
                    .CAPACITY(CAPACITY),
                    .IDX     (i)
                ) u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .ctrl    (ctrl),
                    .live    (live[i]),
                    .prev_val('0),
                    .prev_ge (1'b0),
                    .val     (cell_val[i]),
                    .ge      (cell_ge[i]),
                    .eq      (cell_eq[i]),
                    .rd      (cell_rd[i])
                );
            end
            else
            begin : g_body
                sult_cell #(
                    .CAPACITY(CAPACITY),
                    .IDX     (i)
                ) u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .ctrl    (ctrl),
                    .live    (live[i]),
                    .prev_val(cell_val[i-1]),
                    .prev_ge (cell_ge[i-1]),
                    .val     (cell_val[i]),
                    .ge      (cell_ge[i]),
                    .eq      (cell_eq[i]),
                    .rd      (cell_rd[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        rd_any = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            rd_any = rd_any | cell_rd[k];
        end
    end

    always_comb
    begin
        dup     = |cell_eq;
        full    = (count_reg == CW'(CAPACITY));
        rank_ok = ({CW'(0), rank_reg} < {RW'(0), count_reg}) &&
                  ({CW'(0), rank_reg} < (CW + RW)'(CAPACITY));
        do_ins  = (state_reg == sult_pkg::S_APPLY) && (cmd_reg == sult_pkg::CMD_INSERT) &&
                  !dup && !full;

        ctrl.eval  = (state_reg == sult_pkg::S_EVAL);
        ctrl.ins   = do_ins;
        ctrl.value = val_reg;
        ctrl.rank  = rank_reg;

        count_next   = do_ins ? (count_reg + CW'(1)) : count_reg;
        cnt_ext      = {sult_pkg::COUNT_W'(0), count_next};
        state_next   = state_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        rdval_next   = rdval_reg;
        cnt_out_next = cnt_out_reg;

        case (state_reg)
            sult_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = sult_pkg::S_EVAL;
                end
            end
            sult_pkg::S_EVAL:
            begin
                state_next = sult_pkg::S_APPLY;
            end
            sult_pkg::S_APPLY:
            begin
                state_next   = sult_pkg::S_IDLE;
                done_next    = 1'b1;
                cnt_out_next = cnt_ext[sult_pkg::COUNT_W-1:0];
                rdval_next   = '0;
                if (cmd_reg == sult_pkg::CMD_INSERT)
                begin
                    if (dup)
                    begin
                        status_next = sult_pkg::ST_DUP;
                    end
                    else if (full)
                    begin
                        status_next = sult_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = sult_pkg::ST_OK;
                    end
                end
                else if (rank_ok)
                begin
                    status_next = sult_pkg::ST_OK;
                    rdval_next  = rd_any;
                end
                else
                begin
                    status_next = sult_pkg::ST_RANGE;
                end
            end
            default:
            begin
                state_next = sult_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sult_pkg::S_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            status_reg  <= sult_pkg::ST_OK;
            cnt_out_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdval_reg <= rdval_next;
        if ((state_reg == sult_pkg::S_IDLE) && start)
        begin
            cmd_reg  <= command;
            val_reg  <= value;
            rank_reg <= rank;
        end
    end

    assign busy        = (state_reg != sult_pkg::S_IDLE);
    assign done        = done_reg;
    assign read_value  = rdval_reg;
    assign entry_count = cnt_out_reg;
    assign status      = status_reg;

endmodule

FILE: src/sult_checker.sv
module sult_checker #(
    parameter int CAPACITY = sult_pkg::CAPACITY
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic signed [sult_pkg::VALUE_W-1:0] read_value,
    input logic [sult_pkg::COUNT_W-1:0]        entry_count,
    input logic [1:0]                          status
);

    // Each accepted item yields its result, shown with done high.
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result did not follow an accepted item in three cycles");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_no_extra_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result shown on two cycles in a row");

    // Only a good read carries a nonzero level.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != sult_pkg::ST_OK)) |-> (read_value == '0))
        else $error("nonzero read_value with a non-ok status");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sult_pkg::ST_FULL)) |->
        (entry_count == sult_pkg::COUNT_W'(CAPACITY)))
        else $error("table reported full at a count below capacity");

endmodule

bind sorted_unique_level_table_top sult_checker #(
    .CAPACITY(CAPACITY)
) u_sult_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_value (read_value),
    .entry_count(entry_count),
    .status     (status)
);
